@@ sv/pps_pkg.sv @@
// ----------------------------------------------------------------------------
// pps_pkg: shared types and constants for the positional PID speed loop
// Field widths, register indexes, reset values and stage payload structs.
// ----------------------------------------------------------------------------
package pps_pkg;

   localparam int SPEED_W  = 16;               // measured, target, drive
   localparam int ERR_W    = SPEED_W + 1;      // target - measured
   localparam int DIFF_W   = ERR_W + 1;        // err - last err
   localparam int GAIN_W   = 24;
   localparam int LIMIT_W  = 18;
   localparam int SUM_W    = LIMIT_W + 1;      // clamped error sum
   localparam int RAW_W    = SUM_W + 1;        // sum before clamp
   localparam int FRAC_W   = 20;
   localparam int ACC_W    = 45;               // product and accumulator width
   localparam int Y_W      = ACC_W - FRAC_W;   // after the fraction shift
   localparam int CSR_A_W  = 3;
   localparam int CSR_D_W  = GAIN_W;

   // register indexes
   localparam logic [CSR_A_W-1:0] CSR_GAIN_P    = 3'd0;
   localparam logic [CSR_A_W-1:0] CSR_GAIN_I    = 3'd1;
   localparam logic [CSR_A_W-1:0] CSR_GAIN_D    = 3'd2;
   localparam logic [CSR_A_W-1:0] CSR_OUT_MAX   = 3'd3;
   localparam logic [CSR_A_W-1:0] CSR_OUT_MIN   = 3'd4;
   localparam logic [CSR_A_W-1:0] CSR_INT_LIMIT = 3'd5;

   // reset values
   localparam logic [GAIN_W-1:0]         GAIN_P_RST    = 24'd20972;
   localparam logic [GAIN_W-1:0]         GAIN_I_RST    = 24'd4719;
   localparam logic [GAIN_W-1:0]         GAIN_D_RST    = 24'd0;
   localparam logic signed [SPEED_W-1:0] OUT_MAX_RST   = 16'sd5000;
   localparam logic signed [SPEED_W-1:0] OUT_MIN_RST   = 16'sd0;
   localparam logic [LIMIT_W-1:0]        INT_LIMIT_RST = 18'd220000;

   typedef struct packed {
      logic [GAIN_W-1:0]         gain_p;
      logic [GAIN_W-1:0]         gain_i;
      logic [GAIN_W-1:0]         gain_d;
      logic signed [SPEED_W-1:0] out_max;
      logic signed [SPEED_W-1:0] out_min;
      logic [LIMIT_W-1:0]        integral_limit;
   } cfg_type;

   typedef struct packed {
      logic signed [SPEED_W-1:0] measured;
      logic signed [SPEED_W-1:0] target;
   } sample_type;

   typedef struct packed {
      logic signed [ERR_W-1:0]  err;
      logic signed [SUM_W-1:0]  sum;
      logic signed [DIFF_W-1:0] diff;
   } err_stage_type;

   typedef struct packed {
      logic signed [ACC_W-1:0] prod_p;
      logic signed [ACC_W-1:0] prod_i;
      logic signed [ACC_W-1:0] prod_d;
   } prod_stage_type;

   // per-stage flow control toward a neighbor
   typedef struct packed {
      logic valid;
      logic advance;
   } flow_type;

endpackage

@@ sv/pps_error.sv @@
// ----------------------------------------------------------------------------
// pps_error: error, clamped error sum and error difference
// Owns the loop state; updates it as each sample moves into this stage.
// ----------------------------------------------------------------------------
module pps_error (
   input  logic                   clock,
   input  logic                   reset,
   input  pps_pkg::cfg_type       cfg,
   input  logic                   up_valid,
   input  pps_pkg::sample_type    up_data,
   input  logic                   dn_advance,
   output logic                   advance,
   output logic                   valid,
   output pps_pkg::err_stage_type data
);

   logic                                   valid_ff;
   pps_pkg::err_stage_type                 data_ff;
   pps_pkg::err_stage_type                 data_in;
   logic signed [pps_pkg::ERR_W-1:0]       last_err_ff;
   logic signed [pps_pkg::SUM_W-1:0]       err_sum_ff;
   logic signed [pps_pkg::ERR_W-1:0]       err;
   logic signed [pps_pkg::RAW_W-1:0]       raw_sum;
   logic signed [pps_pkg::RAW_W-1:0]       lim_pos;
   logic signed [pps_pkg::RAW_W-1:0]       lim_neg;
   logic signed [pps_pkg::RAW_W-1:0]       clamped;
   logic                                   take;

   assign advance = !valid_ff || dn_advance;
   assign take    = advance && up_valid;

   always_comb begin
      err     = {up_data.target[pps_pkg::SPEED_W-1], up_data.target}
              - {up_data.measured[pps_pkg::SPEED_W-1], up_data.measured};
      raw_sum = {err_sum_ff[pps_pkg::SUM_W-1], err_sum_ff}
              + {{(pps_pkg::RAW_W-pps_pkg::ERR_W){err[pps_pkg::ERR_W-1]}}, err};
      lim_pos = $signed({{(pps_pkg::RAW_W-pps_pkg::LIMIT_W){1'b0}}, cfg.integral_limit});
      lim_neg = -lim_pos;
      clamped = raw_sum;
      if (clamped > lim_pos) begin
         clamped = lim_pos;
      end
      if (clamped < lim_neg) begin
         clamped = lim_neg;
      end
      // zero target clears the sum
      if (up_data.target == '0) begin
         clamped = '0;
      end
      data_in.err  = err;
      data_in.sum  = clamped[pps_pkg::SUM_W-1:0];
      data_in.diff = {err[pps_pkg::ERR_W-1], err}
                   - {last_err_ff[pps_pkg::ERR_W-1], last_err_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         last_err_ff <= '0;
         err_sum_ff  <= '0;
      end else begin
         if (advance) begin
            valid_ff <= up_valid;
         end
         if (take) begin
            last_err_ff <= err;
            err_sum_ff  <= clamped[pps_pkg::SUM_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= data_in;
      end
   end

   assign valid = valid_ff;
   assign data  = data_ff;

endmodule

@@ sv/pps_mult.sv @@
// ----------------------------------------------------------------------------
// pps_mult: gain products
// Three 25x19-class signed multiplies, each registered.
// ----------------------------------------------------------------------------
module pps_mult (
   input  logic                    clock,
   input  logic                    reset,
   input  pps_pkg::cfg_type        cfg,
   input  logic                    up_valid,
   input  pps_pkg::err_stage_type  up_data,
   input  logic                    dn_advance,
   output logic                    advance,
   output logic                    valid,
   output pps_pkg::prod_stage_type data
);

   logic                                valid_ff;
   pps_pkg::prod_stage_type             data_ff;
   pps_pkg::prod_stage_type             data_in;
   logic signed [pps_pkg::GAIN_W:0]     gp;
   logic signed [pps_pkg::GAIN_W:0]     gi;
   logic signed [pps_pkg::GAIN_W:0]     gd;

   assign advance = !valid_ff || dn_advance;

   always_comb begin
      // gains are unsigned: prepend a zero sign bit
      gp = $signed({1'b0, cfg.gain_p});
      gi = $signed({1'b0, cfg.gain_i});
      gd = $signed({1'b0, cfg.gain_d});
      // sign-extend both operands to the product width
      data_in.prod_p = pps_pkg::ACC_W'(gp) * pps_pkg::ACC_W'(up_data.err);
      data_in.prod_i = pps_pkg::ACC_W'(gi) * pps_pkg::ACC_W'(up_data.sum);
      data_in.prod_d = pps_pkg::ACC_W'(gd) * pps_pkg::ACC_W'(up_data.diff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign valid = valid_ff;
   assign data  = data_ff;

endmodule

@@ sv/pps_out.sv @@
// ----------------------------------------------------------------------------
// pps_out: product sum, fraction shift and output clamp
// Holds the result register that drives the output channel.
// ----------------------------------------------------------------------------
module pps_out (
   input  logic                             clock,
   input  logic                             reset,
   input  pps_pkg::cfg_type                 cfg,
   input  logic                             up_valid,
   input  pps_pkg::prod_stage_type          up_data,
   input  logic                             dn_ready,
   output logic                             advance,
   output logic                             valid,
   output logic signed [pps_pkg::SPEED_W-1:0] drive
);

   logic                                   valid_ff;
   logic signed [pps_pkg::SPEED_W-1:0]     drive_ff;
   logic signed [pps_pkg::SPEED_W-1:0]     drive_in;
   logic signed [pps_pkg::ACC_W-1:0]       acc;
   logic signed [pps_pkg::Y_W-1:0]         y;
   logic signed [pps_pkg::Y_W-1:0]         hi;
   logic signed [pps_pkg::Y_W-1:0]         lo;

   assign advance = !valid_ff || dn_ready;

   always_comb begin
      acc = up_data.prod_p + up_data.prod_i + up_data.prod_d;
      // drop fraction bits: floor toward minus infinity
      y   = acc[pps_pkg::ACC_W-1:pps_pkg::FRAC_W];
      hi  = {{(pps_pkg::Y_W-pps_pkg::SPEED_W){cfg.out_max[pps_pkg::SPEED_W-1]}}, cfg.out_max};
      lo  = {{(pps_pkg::Y_W-pps_pkg::SPEED_W){cfg.out_min[pps_pkg::SPEED_W-1]}}, cfg.out_min};
      // upper bound first, lower bound wins when bounds cross
      if (y > hi) begin
         y = hi;
      end
      if (y < lo) begin
         y = lo;
      end
      drive_in = y[pps_pkg::SPEED_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && up_valid) begin
         drive_ff <= drive_in;
      end
   end

   assign valid = valid_ff;
   assign drive = drive_ff;

endmodule

@@ sv/positional_pid_speed.sv @@
// ----------------------------------------------------------------------------
// positional_pid_speed: positional PID speed controller with integral clamp
// Streams measured/target samples in and clamped drive values out.
// ----------------------------------------------------------------------------
// Each transfer on the req_ channel carries one speed sample; exactly one
// drive value leaves on the rsp_ channel for it, in order. The block is a
// four-register pipeline (input, error/sum, products, result) and takes a
// new sample every cycle while the output side is not stalled; a sample's
// drive value moves through the error/sum, products and result registers
// before it is offered on rsp_. Each stage holds its item only while the
// stage after it is full and stalled, so the input keeps accepting while a
// finished result waits, until all stages fill. The error sum and previous
// error are updated as a sample enters the error stage, which is a single
// add and clamp, so consecutive samples never wait on each other. Gains,
// output bounds and the integral limit are written through csr_; write them
// only while no sample is in flight. Register indexes 6 and 7 are ignored.
// ----------------------------------------------------------------------------
module positional_pid_speed (
   input  logic                          clock,
   input  logic                          reset,
   // input channel
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [2*pps_pkg::SPEED_W-1:0] req_tdata,  // [15:0] measured, [31:16] target
   // result channel
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [pps_pkg::SPEED_W-1:0]   rsp_tdata,  // [15:0] drive
   // configuration writes
   input  logic                          csr_we,
   input  logic [pps_pkg::CSR_A_W-1:0]   csr_addr,
   input  logic [pps_pkg::CSR_D_W-1:0]   csr_wdata
);

   pps_pkg::cfg_type                     cfg_ff;
   logic                                 in_valid_ff;
   pps_pkg::sample_type                  in_data_ff;
   pps_pkg::err_stage_type               err_data;
   pps_pkg::prod_stage_type              prod_data;
   pps_pkg::flow_type                    err_flow;
   pps_pkg::flow_type                    mult_flow;
   pps_pkg::flow_type                    out_flow;
   logic                                 in_advance;
   logic signed [pps_pkg::SPEED_W-1:0]   drive;

   // ---- configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p         <= pps_pkg::GAIN_P_RST;
         cfg_ff.gain_i         <= pps_pkg::GAIN_I_RST;
         cfg_ff.gain_d         <= pps_pkg::GAIN_D_RST;
         cfg_ff.out_max        <= pps_pkg::OUT_MAX_RST;
         cfg_ff.out_min        <= pps_pkg::OUT_MIN_RST;
         cfg_ff.integral_limit <= pps_pkg::INT_LIMIT_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            pps_pkg::CSR_GAIN_P: begin
               cfg_ff.gain_p <= csr_wdata;
            end
            pps_pkg::CSR_GAIN_I: begin
               cfg_ff.gain_i <= csr_wdata;
            end
            pps_pkg::CSR_GAIN_D: begin
               cfg_ff.gain_d <= csr_wdata;
            end
            pps_pkg::CSR_OUT_MAX: begin
               cfg_ff.out_max <= $signed(csr_wdata[pps_pkg::SPEED_W-1:0]);
            end
            pps_pkg::CSR_OUT_MIN: begin
               cfg_ff.out_min <= $signed(csr_wdata[pps_pkg::SPEED_W-1:0]);
            end
            pps_pkg::CSR_INT_LIMIT: begin
               cfg_ff.integral_limit <= csr_wdata[pps_pkg::LIMIT_W-1:0];
            end
            default: begin
               // unmapped index: drop the write
            end
         endcase
      end
   end

   // ---- input register: free when empty or when the error stage takes it
   assign in_advance = !in_valid_ff || err_flow.advance;
   assign req_tready = in_advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_advance) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_advance && req_tvalid) begin
         in_data_ff.measured <= $signed(req_tdata[pps_pkg::SPEED_W-1:0]);
         in_data_ff.target   <= $signed(req_tdata[2*pps_pkg::SPEED_W-1:pps_pkg::SPEED_W]);
      end
   end

   // ---- error, sum and difference; owns the loop state
   pps_error u_error (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .up_valid   (in_valid_ff),
      .up_data    (in_data_ff),
      .dn_advance (mult_flow.advance),
      .advance    (err_flow.advance),
      .valid      (err_flow.valid),
      .data       (err_data)
   );

   // ---- gain products
   pps_mult u_mult (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .up_valid   (err_flow.valid),
      .up_data    (err_data),
      .dn_advance (out_flow.advance),
      .advance    (mult_flow.advance),
      .valid      (mult_flow.valid),
      .data       (prod_data)
   );

   // ---- sum, shift, clamp and result register
   pps_out u_out (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .up_valid (mult_flow.valid),
      .up_data  (prod_data),
      .dn_ready (rsp_tready),
      .advance  (out_flow.advance),
      .valid    (out_flow.valid),
      .drive    (drive)
   );

   assign rsp_tvalid = out_flow.valid;
   assign rsp_tdata  = drive;

endmodule

@@ dv/positional_pid_speed_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_pid_speed_tb: self-checking bench for the positional PID speed loop
// Walks a directed row list (register writes and samples), then random phases
// with fresh gains, bounds and integral limits. A predictor keeps
// its own error sum and previous error and queues one drive value per sample;
// every rsp_ transfer is compared against the oldest queued value.
// ----------------------------------------------------------------------------
module positional_pid_speed_tb;

   // spare register indexes; writes to them must leave every register alone
   localparam logic [pps_pkg::CSR_A_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [pps_pkg::CSR_A_W-1:0] CSR_SPARE_HI = 3'd7;

   localparam int NUM_PHASES   = 6;
   localparam int PHASE_ITEMS  = 172;
   localparam int STEADY_PHASE = 2;     // neither side idles in this phase
   localparam int PAUSE_PHASE  = 4;     // sender drains the pipe once in here
   localparam int PAUSE_AT     = 80;
   localparam int HOLD_AT      = 640;   // samples sent before the long rsp_ stall
   localparam int HOLD_CYCLES  = 300;
   localparam int TAIL_CYCLES  = 16;    // pipeline is four deep; allow a margin
   localparam int PRED_W       = 48;    // predictor accumulator width
   // ~1055 samples; even with 25% idling on both sides, the phase drains and
   // the long stall, a correct run stays well below this limit
   localparam int CYCLE_LIMIT  = 200000;

   typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_type;

   // one directed step: either a register write or a sample, optionally with
   // a drive value that is obvious from the setup (clamps, zero gains)
   typedef struct packed {
      row_kind_type                    kind;
      logic [pps_pkg::CSR_A_W-1:0]     addr;
      logic [pps_pkg::CSR_D_W-1:0]     wdata;
      logic [pps_pkg::SPEED_W-1:0]     measured;
      logic [pps_pkg::SPEED_W-1:0]     target;
      logic                            typed;
      logic [pps_pkg::SPEED_W-1:0]     drive;
   } stim_row_type;

   localparam int NUM_ROWS = 41;
   localparam stim_row_type DIRECTED_ROWS [NUM_ROWS] = '{
      // reset settings: zero sample, then a full negative error clamps to out_min
      '{ROW_SAMPLE, '0, '0, 16'h0000, 16'h0000, 1'b1, 16'd0},
      '{ROW_SAMPLE, '0, '0, 16'h7FFF, 16'h8000, 1'b1, 16'd0},
      // full positive error five times: the sum climbs into the integral limit
      '{ROW_SAMPLE, '0, '0, 16'h8000, 16'h7FFF, 1'b0, 16'd0},
      '{ROW_SAMPLE, '0, '0, 16'h8000, 16'h7FFF, 1'b0, 16'd0},
      '{ROW_SAMPLE, '0, '0, 16'h8000, 16'h7FFF, 1'b0, 16'd0},
      '{ROW_SAMPLE, '0, '0, 16'h8000, 16'h7FFF, 1'b0, 16'd0},
      '{ROW_SAMPLE, '0, '0, 16'h8000, 16'h7FFF, 1'b0, 16'd0},
      // zero target clears the sum; the P term alone is negative
      '{ROW_SAMPLE, '0, '0, 16'd1000,  16'h0000, 1'b1, 16'd0},
      '{ROW_SAMPLE, '0, '0, 16'h0000, 16'd1234,  1'b0, 16'd0},
      // every gain at full scale, widest bounds (upper wdata bits are dropped)
      '{ROW_WRITE,  pps_pkg::CSR_GAIN_P,  24'hFFFFFF, '0, '0, 1'b0, '0},
      '{ROW_WRITE,  pps_pkg::CSR_GAIN_I,  24'hFFFFFF, '0, '0, 1'b0, '0},
      '{ROW_WRITE,  pps_pkg::CSR_GAIN_D,  24'hFFFFFF, '0, '0, 1'b0, '0},
      '{ROW_WRITE,  pps_pkg::CSR_OUT_MAX, 24'hFF7FFF, '0, '0, 1'b0, '0},
      '{ROW_WRITE,  pps_pkg::CSR_OUT_MIN, 24'h008000, '0, '0, 1'b0, '0},
      '{ROW_SAMPLE, '0, '0, 16'h8000, 16'h7FFF, 1'b1, 16'h7FFF},
      '{ROW_SAMPLE, '0, '0, 16'h7FFF, 16'h8000, 1'b1, 16'h8000},
      '{ROW_SAMPLE, '0, '0, 16'h0001, 16'h0000, 1'b0, 16'd0},
      // all gains zero: output is zero whatever the error
      '{ROW_WRITE,  pps_pkg::CSR_GAIN_P,  24'h000000, '0, '0, 1'b0, '0},
      '{ROW_WRITE,  pps_pkg::CSR_GAIN_I,  24'h000000, '0, '0, 1'b0, '0},
      '{ROW_WRITE,  pps_pkg::CSR_GAIN_D,  24'h000000, '0, '0, 1'b0, '0},
      '{ROW_SAMPLE, '0, '0, 16'd12345, 16'hEF1F, 1'b1, 16'd0},
      // inverted bounds: drive lands on out_min
      '{ROW_WRITE,  pps_pkg::CSR_OUT_MAX, 24'h00FF9C, '0, '0, 1'b0, '0},
      '{ROW_WRITE,  pps_pkg::CSR_OUT_MIN, 24'h000064, '0, '0, 1'b0, '0},
      '{ROW_SAMPLE, '0, '0, 16'd5,     16'd5,     1'b1, 16'd100},
      '{ROW_SAMPLE, '0, '0, 16'h8000, 16'h7FFF, 1'b1, 16'd100},
      // zero integral limit with full I gain: the sum stays at zero
      '{ROW_WRITE,  pps_pkg::CSR_INT_LIMIT, 24'h000000, '0, '0, 1'b0, '0},
      '{ROW_WRITE,  pps_pkg::CSR_GAIN_I,    24'hFFFFFF, '0, '0, 1'b0, '0},
      '{ROW_WRITE,  pps_pkg::CSR_OUT_MAX,   24'h007FFF, '0, '0, 1'b0, '0},
      '{ROW_WRITE,  pps_pkg::CSR_OUT_MIN,   24'h008000, '0, '0, 1'b0, '0},
      '{ROW_SAMPLE, '0, '0, 16'h0000, 16'd100,   1'b1, 16'd0},
      '{ROW_SAMPLE, '0, '0, 16'h0000, 16'hFF9C, 1'b1, 16'd0},
      // spare indexes are ignored: P gain must stay zero
      '{ROW_WRITE,  CSR_SPARE_LO, 24'hFFFFFF, '0, '0, 1'b0, '0},
      '{ROW_WRITE,  CSR_SPARE_HI, 24'hFFFFFF, '0, '0, 1'b0, '0},
      '{ROW_SAMPLE, '0, '0, 16'd7,     16'd3,     1'b1, 16'd0},
      // largest integral limit (masked from all ones), I gain of exactly one
      '{ROW_WRITE,  pps_pkg::CSR_INT_LIMIT, 24'hFFFFFF, '0, '0, 1'b0, '0},
      '{ROW_WRITE,  pps_pkg::CSR_GAIN_I,    24'h100000, '0, '0, 1'b0, '0},
      '{ROW_SAMPLE, '0, '0, 16'h8000, 16'h7FFF, 1'b0, 16'd0},
      '{ROW_SAMPLE, '0, '0, 16'h8000, 16'h7FFF, 1'b0, 16'd0},
      '{ROW_SAMPLE, '0, '0, 16'h8000, 16'h7FFF, 1'b0, 16'd0},
      '{ROW_SAMPLE, '0, '0, 16'h8000, 16'h7FFF, 1'b0, 16'd0},
      '{ROW_SAMPLE, '0, '0, 16'd10,    16'h0000, 1'b1, 16'd0}
   };

   logic                                 clock;
   logic                                 reset;
   logic                                 req_tvalid;
   logic                                 req_tready;
   logic [2*pps_pkg::SPEED_W-1:0]        req_tdata;   // [15:0] measured, [31:16] target
   logic                                 rsp_tvalid;
   logic                                 rsp_tready;
   logic [pps_pkg::SPEED_W-1:0]          rsp_tdata;   // [15:0] drive
   logic                                 csr_we;
   logic [pps_pkg::CSR_A_W-1:0]          csr_addr;
   logic [pps_pkg::CSR_D_W-1:0]          csr_wdata;

   // predictor copy of the registers and loop state
   pps_pkg::cfg_type                     ctrl_cfg;
   logic signed [pps_pkg::SUM_W-1:0]     err_sum;
   logic signed [pps_pkg::ERR_W-1:0]     prev_err;

   logic [pps_pkg::SPEED_W-1:0]          drive_q[$];  // drive values still owed
   int                                   mismatches;
   int                                   samples_sent;
   int                                   cycles;
   bit                                   steady;       // suppress idling on both sides
   bit                                   stall_done;

   positional_pid_speed i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------------
   function automatic void reset_loop_model();
      ctrl_cfg = '{pps_pkg::GAIN_P_RST, pps_pkg::GAIN_I_RST, pps_pkg::GAIN_D_RST,
                   pps_pkg::OUT_MAX_RST, pps_pkg::OUT_MIN_RST, pps_pkg::INT_LIMIT_RST};
      err_sum  = '0;
      prev_err = '0;
   endfunction

   function automatic void apply_reg(input logic [pps_pkg::CSR_A_W-1:0] addr,
                                     input logic [pps_pkg::CSR_D_W-1:0] data);
      case (addr)
         pps_pkg::CSR_GAIN_P:    ctrl_cfg.gain_p = data;
         pps_pkg::CSR_GAIN_I:    ctrl_cfg.gain_i = data;
         pps_pkg::CSR_GAIN_D:    ctrl_cfg.gain_d = data;
         pps_pkg::CSR_OUT_MAX:   ctrl_cfg.out_max = data[pps_pkg::SPEED_W-1:0];
         pps_pkg::CSR_OUT_MIN:   ctrl_cfg.out_min = data[pps_pkg::SPEED_W-1:0];
         pps_pkg::CSR_INT_LIMIT: ctrl_cfg.integral_limit = data[pps_pkg::LIMIT_W-1:0];
         default: ;     // spare index: drop the write
      endcase
   endfunction

   // one control step: update sum and previous error, return the clamped drive
   function automatic logic [pps_pkg::SPEED_W-1:0] predict_drive(
      input logic signed [pps_pkg::SPEED_W-1:0] measured,
      input logic signed [pps_pkg::SPEED_W-1:0] target);
      logic signed [pps_pkg::ERR_W-1:0]  err;
      logic signed [pps_pkg::RAW_W-1:0]  raw;
      logic signed [pps_pkg::RAW_W-1:0]  lim;
      logic signed [pps_pkg::DIFF_W-1:0] diff;
      logic signed [PRED_W-1:0]          acc;
      logic signed [PRED_W-1:0]          hi;
      logic signed [PRED_W-1:0]          lo;
      err  = pps_pkg::ERR_W'(target) - pps_pkg::ERR_W'(measured);
      raw  = pps_pkg::RAW_W'(err_sum) + pps_pkg::RAW_W'(err);
      lim  = $signed({2'b00, ctrl_cfg.integral_limit});
      if (raw > lim) raw = lim;
      if (raw < -lim) raw = -lim;
      if (target == '0) raw = '0;
      diff = pps_pkg::DIFF_W'(err) - pps_pkg::DIFF_W'(prev_err);
      acc  = PRED_W'($signed({1'b0, ctrl_cfg.gain_p})) * PRED_W'(err)
           + PRED_W'($signed({1'b0, ctrl_cfg.gain_i})) * PRED_W'(raw)
           + PRED_W'($signed({1'b0, ctrl_cfg.gain_d})) * PRED_W'(diff);
      acc  = acc >>> pps_pkg::FRAC_W;       // floor toward minus infinity
      hi   = PRED_W'($signed(ctrl_cfg.out_max));
      lo   = PRED_W'($signed(ctrl_cfg.out_min));
      // upper bound first, lower second: inverted bounds give out_min
      if (acc > hi) acc = hi;
      if (acc < lo) acc = lo;
      err_sum  = raw[pps_pkg::SUM_W-1:0];
      prev_err = err;
      return acc[pps_pkg::SPEED_W-1:0];
   endfunction

   // ------------------------------------------------------------------------
   // random picks
   // ------------------------------------------------------------------------
   function automatic logic [pps_pkg::CSR_D_W-1:0] pick_gain();
      int r;
      r = $urandom_range(99);
      if (r < 50) return pps_pkg::CSR_D_W'($urandom_range(0, 1 << 17));  // typical gains
      if (r < 70) return pps_pkg::CSR_D_W'($urandom_range(0, 1 << 20));  // up to unity
      if (r < 85) return pps_pkg::CSR_D_W'($urandom);
      return $urandom_range(1) ? '1 : '0;
   endfunction

   function automatic logic [pps_pkg::SPEED_W-1:0] pick_extreme();
      case ($urandom_range(4))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'hFFFF;
         3:       return 16'h0001;
         default: return 16'h0000;
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // drivers
   // ------------------------------------------------------------------------
   // Drop valid and hold until the block has returned everything owed.
   task automatic drain_pipe();
      req_tvalid <= 1'b0;
      while (drive_q.size() != 0) @(posedge clock);
   endtask

   // Write one register; we stays high until the next sample lowers it.
   task automatic write_reg(input logic [pps_pkg::CSR_A_W-1:0] addr,
                            input logic [pps_pkg::CSR_D_W-1:0] data);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(posedge clock);
      apply_reg(addr, data);
   endtask

   // Offer one sample after random idle cycles; queue its drive on transfer.
   task automatic send_sample(input logic [pps_pkg::SPEED_W-1:0] measured,
                              input logic [pps_pkg::SPEED_W-1:0] target,
                              input logic                        typed,
                              input logic [pps_pkg::SPEED_W-1:0] typed_drive);
      logic [pps_pkg::SPEED_W-1:0] want;
      logic                        taken;
      csr_we <= 1'b0;
      while (!steady && $urandom_range(99) < 25) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {target, measured};
      // ready is settled at the falling edge; the transfer happens at the next rise
      do begin
         @(negedge clock);
         taken = req_tready;
         @(posedge clock);
      end while (!taken);
      want = predict_drive(measured, target);
      if (typed) want = typed_drive;
      drive_q.push_back(want);
      samples_sent++;
   endtask

   // New gains, bounds and limit for a random phase, extremes included.
   task automatic program_random_regs();
      int                          r;
      logic [pps_pkg::SPEED_W-1:0] hi;
      logic [pps_pkg::SPEED_W-1:0] lo;
      logic [pps_pkg::CSR_D_W-1:0] lim;
      write_reg(pps_pkg::CSR_GAIN_P, pick_gain());
      write_reg(pps_pkg::CSR_GAIN_I, pick_gain());
      write_reg(pps_pkg::CSR_GAIN_D, pick_gain());
      r = $urandom_range(99);
      if (r < 70) begin
         hi = pps_pkg::SPEED_W'($urandom_range(1000, 32767));
         lo = pps_pkg::SPEED_W'(-$urandom_range(0, 32768));
      end else if (r < 85) begin
         hi = pps_pkg::SPEED_W'($urandom);          // may come out inverted
         lo = pps_pkg::SPEED_W'($urandom);
      end else begin
         hi = 16'h7FFF;
         lo = 16'h8000;
      end
      // upper wdata bits are don't-care for the bounds; toggle them anyway
      write_reg(pps_pkg::CSR_OUT_MAX, {8'($urandom), hi});
      write_reg(pps_pkg::CSR_OUT_MIN, {8'($urandom), lo});
      r = $urandom_range(99);
      if (r < 60)      lim = pps_pkg::CSR_D_W'($urandom_range(1000, 262143));
      else if (r < 75) lim = '0;
      else if (r < 90) lim = {6'($urandom), 18'h3FFFF};
      else             lim = pps_pkg::CSR_D_W'($urandom);
      write_reg(pps_pkg::CSR_INT_LIMIT, lim);
      if ($urandom_range(2) == 0)
         write_reg($urandom_range(1) ? CSR_SPARE_LO : CSR_SPARE_HI,
                   pps_pkg::CSR_D_W'($urandom));
   endtask

   // ------------------------------------------------------------------------
   // result side: random idling, plus one long stall while samples keep coming
   // ------------------------------------------------------------------------
   initial begin : rsp_side
      int k;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         if (!stall_done && samples_sent >= HOLD_AT) begin
            // hold off long enough for the pipe to fill and stall req_
            rsp_tready <= 1'b0;
            for (k = 0; k < HOLD_CYCLES; k++) @(posedge clock);
            stall_done = 1'b1;
         end else begin
            rsp_tready <= steady || ($urandom_range(99) >= 25);
            @(posedge clock);
         end
      end
   end

   // Compare each drive transfer against the oldest queued value. Signals are
   // stable at the falling edge, and a transfer seen here completes at the next rise.
   always @(negedge clock) begin : check_drive
      logic [pps_pkg::SPEED_W-1:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (drive_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: drive %0d transferred with nothing owed", $realtime,
                        $signed(rsp_tdata));
         end else begin
            want = drive_q.pop_front();
            if (rsp_tdata !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: drive mismatch, expected %0d, got %0d", $realtime,
                           $signed(want), $signed(rsp_tdata));
            end
         end
      end
   end

   // Watchdog: a hung handshake ends the run here.
   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles >= CYCLE_LIMIT) begin
            $display("positional_pid_speed regression: fail");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   initial begin : stimulus
      int                          row_i;
      int                          phase;
      int                          item;
      int                          pick;
      stim_row_type                row;
      logic [pps_pkg::SPEED_W-1:0] measured;
      logic [pps_pkg::SPEED_W-1:0] target;
      logic [pps_pkg::SPEED_W-1:0] set_speed;

      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      csr_we       = 1'b0;
      csr_addr     = '0;
      csr_wdata    = '0;
      mismatches   = 0;
      samples_sent = 0;
      steady       = 1'b0;
      stall_done   = 1'b0;
      reset_loop_model();

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed rows; writes only once every owed drive has come back
      for (row_i = 0; row_i < NUM_ROWS; row_i++) begin
         row = DIRECTED_ROWS[row_i];
         if (row.kind == ROW_WRITE) begin
            drain_pipe();
            write_reg(row.addr, row.wdata);
         end else begin
            send_sample(row.measured, row.target, row.typed, row.drive);
         end
      end

      // random phases: mostly tracking a setpoint with noise, some zero
      // targets, full-range noise and extremes
      for (phase = 0; phase < NUM_PHASES; phase++) begin
         drain_pipe();
         program_random_regs();
         steady    = (phase == STEADY_PHASE);
         set_speed = pps_pkg::SPEED_W'($urandom);
         for (item = 0; item < PHASE_ITEMS; item++) begin
            if ($urandom_range(49) == 0) set_speed = pps_pkg::SPEED_W'($urandom);
            pick = $urandom_range(99);
            if (pick < 10) begin
               measured = pps_pkg::SPEED_W'($urandom);
               target   = '0;
            end else if (pick < 60) begin
               target   = set_speed;
               measured = set_speed + pps_pkg::SPEED_W'($urandom_range(0, 1000) - 500);
            end else if (pick < 85) begin
               measured = pps_pkg::SPEED_W'($urandom);
               target   = pps_pkg::SPEED_W'($urandom);
            end else begin
               measured = pick_extreme();
               target   = pick_extreme();
            end
            send_sample(measured, target, 1'b0, '0);
            // pause the sender once until the block has caught up completely
            if (phase == PAUSE_PHASE && item == PAUSE_AT) drain_pipe();
         end
      end
      steady = 1'b0;

      drain_pipe();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && drive_q.size() == 0) begin
         $display("positional_pid_speed regression: pass");
      end else begin
         $display("positional_pid_speed regression: fail");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
sv/pps_pkg.sv
sv/pps_error.sv
sv/pps_mult.sv
sv/pps_out.sv
sv/positional_pid_speed.sv
dv/positional_pid_speed_tb.sv
